// File: sv/tcig_pkg.sv
// ----------------------------------------------------------------------------
// tcig_pkg
// Types, constants and helpers shared by the turn circle initial guess block.
// ----------------------------------------------------------------------------
`default_nettype none

package tcig_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 1;
    localparam int QUOT_BITS    = 36;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [34:0]        IX_LIMIT    = 35'h3_FFFF_FFFF;

    localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    typedef enum logic {
        REG_TURN_RADIUS    = 1'b0,
        REG_HEADING_OFFSET = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic signed [31:0] goal_x;
        logic signed [31:0] goal_y;
        logic [15:0]        goal_heading;
        logic signed [31:0] robot_x;
        logic signed [31:0] robot_y;
        logic [15:0]        push_heading;
    } pose_t;

    typedef struct packed {
        logic signed [31:0] guess_x;
        logic signed [31:0] guess_y;
        logic               guess_valid;
    } guess_t;

    typedef struct packed {
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic               ortho;
        logic               left;
        logic               dz;
    } front_t;

    typedef struct packed {
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic               ortho;
        logic               left;
        logic               dz;
        logic signed [31:0] pc;
        logic signed [31:0] ps;
        logic signed [31:0] dc;
        logic signed [31:0] ds;
        logic signed [64:0] p_cdx;
        logic signed [64:0] p_sdy;
        logic signed [64:0] p_cdy;
        logic signed [64:0] p_sdx;
        logic signed [63:0] p_rc;
        logic [30:0]        r;
    } mid_t;

    typedef struct packed {
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [31:0] pc;
        logic signed [31:0] ps;
        logic signed [31:0] dc;
        logic signed [31:0] ds;
        logic               dz;
        logic signed [35:0] xg;
        logic signed [35:0] yg;
        logic signed [34:0] py;
        logic               xz;
        logic               yz;
        logic               sz;
    } back_t;

    typedef struct packed {
        back_t                  b;
        logic                   neg;
        logic                   ovf;
        logic [29:0]            rem;
        logic [28:0]            ad;
        logic [QUOT_BITS-1:0]   lo;
        logic [QUOT_BITS-1:0]   q;
    } div_t;

    function automatic logic signed [41:0] rnd_trig(input logic signed [69:0] v);
        logic signed [69:0] t;
        t = v + 70'sd134217728;
        return 42'(t >>> 28);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
        if (v > 43'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -43'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic div_t div_step(input div_t x);
        div_t        y;
        logic [29:0] r2;
        logic        ge;
        y  = x;
        r2 = {x.rem[28:0], x.lo[QUOT_BITS-1]};
        ge = (r2 >= {1'b0, x.ad});
        y.rem = ge ? (r2 - {1'b0, x.ad}) : r2;
        y.q   = {x.q[QUOT_BITS-2:0], ge};
        y.lo  = {x.lo[QUOT_BITS-2:0], 1'b0};
        return y;
    endfunction

endpackage

`default_nettype wire

// File: sv/turn_circle_initial_guess.sv
// ----------------------------------------------------------------------------
// turn_circle_initial_guess
// Initial guess for a pre-push pose from a goal pose and a push start pose.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  pose     | in        | pose_valid/pose_stall | tcig_pkg::pose_t
//  res      | out       | res_valid/res_stall   | tcig_pkg::guess_t
//  apb      | in/out    | psel/penable/pready   | turn_radius, heading_offset
//
//  One item per cycle while no result waits under res_stall; 77 register
//  stages (three 31-stage CORDICs in parallel, then a 36-stage restoring
//  divider for the intersection).
//  The whole pipeline holds while a result waits under res_stall.
//  Reset clears valid bits and heading_offset and sets turn_radius to 1.0;
//  data stages are not reset.
`default_nettype none

module turn_circle_initial_guess #(
    parameter int COORD_FRAC_BITS = 16,
    parameter int ANGLE_BITS      = 16,
    parameter int ORTHO_TOLERANCE = 104
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              pose_valid,
    output logic                   pose_stall,
    input  wire tcig_pkg::pose_t   pose,
    output logic                   res_valid,
    input  wire logic              res_stall,
    output tcig_pkg::guess_t       res,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import tcig_pkg::*;

    localparam int AB = ANGLE_BITS;
    localparam logic [AB-1:0] HALF = AB'(1) << (AB - 1);
    localparam logic signed [AB+1:0] QUARTER = (AB+2)'(1) << (AB - 2);
    localparam logic signed [AB+1:0] THREE_QUARTER = (AB+2)'(3) << (AB - 2);
    localparam logic signed [AB+1:0] TOL = (AB+2)'(ORTHO_TOLERANCE);

    logic [30:0] turn_radius_reg;
    logic [15:0] heading_offset_reg;
    reg_idx_t    widx;

    logic en;
    assign en         = !(res_valid && res_stall);
    assign pose_stall = !en;
    assign pready     = 1'b1;
    assign widx       = reg_idx_t'(paddr[2]);

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turn_radius_reg    <= 31'(1) << COORD_FRAC_BITS;
            heading_offset_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (widx)
                REG_TURN_RADIUS:    turn_radius_reg    <= pwdata[30:0];
                REG_HEADING_OFFSET: heading_offset_reg <= pwdata[15:0];
                default:            turn_radius_reg    <= turn_radius_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (widx)
            REG_TURN_RADIUS:    prdata = {1'b0, turn_radius_reg};
            REG_HEADING_OFFSET: prdata = {16'b0, heading_offset_reg};
            default:            prdata = '0;
        endcase
    end

    // stage A: frame differences, relative heading, circle choice
    logic [AB-1:0]        gh, ph, d_next, off, phl, phr;
    logic signed [AB+1:0] e1, e3;
    front_t               a_next, a_reg;
    logic                 va_reg;
    logic [31:0]          ang_p_reg, ang_c_reg, ang_d_reg;

    always_comb
    begin
        gh     = AB'(pose.goal_heading);
        ph     = AB'(pose.push_heading);
        d_next = gh - ph;
        off    = AB'(heading_offset_reg);
        phl    = d_next - off;
        phr    = AB'(0) - d_next - off;
        e1     = $signed({2'b00, d_next}) - QUARTER;
        e3     = $signed({2'b00, d_next}) - THREE_QUARTER;
        a_next.rx    = pose.robot_x;
        a_next.ry    = pose.robot_y;
        a_next.dx    = 33'(pose.goal_x) - 33'(pose.robot_x);
        a_next.dy    = 33'(pose.goal_y) - 33'(pose.robot_y);
        a_next.ortho = ((e1 < 0 ? -e1 : e1) <= TOL) || ((e3 < 0 ? -e3 : e3) <= TOL);
        a_next.left  = (phl <= phr);
        a_next.dz    = (d_next == '0) || (d_next == HALF);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg     <= a_next;
            ang_p_reg <= {ph, {(32-AB){1'b0}}};
            ang_c_reg <= {(a_next.left ? phl : phr), {(32-AB){1'b0}}};
            ang_d_reg <= {d_next, {(32-AB){1'b0}}};
        end
    end

    logic signed [31:0] pc_q, ps_q, cc_q, dc_q, ds_q;

    tcig_cordic u_cord_push (
        .clk(clk), .en(en), .ang(ang_p_reg), .cos_q(pc_q), .sin_q(ps_q)
    );
    tcig_cordic u_cord_circ (
        .clk(clk), .en(en), .ang(ang_c_reg), .cos_q(cc_q), .sin_q()
    );
    tcig_cordic u_cord_diff (
        .clk(clk), .en(en), .ang(ang_d_reg), .cos_q(dc_q), .sin_q(ds_q)
    );

    // hold sideband alongside the CORDICs
    front_t                cdl_reg [CORDIC_LAT];
    logic [CORDIC_LAT-1:0] cdv_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cdl_reg[0] <= a_reg;
            for (int k = 1; k < CORDIC_LAT; k++)
                cdl_reg[k] <= cdl_reg[k-1];
        end
    end

    // M1: products
    front_t cf;
    mid_t   m1_next, m1_reg;
    assign cf = cdl_reg[CORDIC_LAT-1];

    always_comb
    begin
        m1_next.rx    = cf.rx;
        m1_next.ry    = cf.ry;
        m1_next.ortho = cf.ortho;
        m1_next.left  = cf.left;
        m1_next.dz    = cf.dz;
        m1_next.pc    = pc_q;
        m1_next.ps    = ps_q;
        m1_next.dc    = dc_q;
        m1_next.ds    = ds_q;
        m1_next.p_cdx = pc_q * cf.dx;
        m1_next.p_sdy = ps_q * cf.dy;
        m1_next.p_cdy = pc_q * cf.dy;
        m1_next.p_sdx = ps_q * cf.dx;
        m1_next.p_rc  = $signed({1'b0, turn_radius_reg}) * cc_q;
        m1_next.r     = turn_radius_reg;
    end

    // M2: goal in push frame, circle height
    back_t              m2_next, m2_reg;
    logic signed [41:0] rc_r;
    logic signed [34:0] h;

    always_comb
    begin
        rc_r = rnd_trig(70'(m1_reg.p_rc));
        h    = 35'($signed({1'b0, m1_reg.r})) - 35'(rc_r);
        m2_next.rx = m1_reg.rx;
        m2_next.ry = m1_reg.ry;
        m2_next.pc = m1_reg.pc;
        m2_next.ps = m1_reg.ps;
        m2_next.dc = m1_reg.dc;
        m2_next.ds = m1_reg.ds;
        m2_next.dz = m1_reg.dz;
        m2_next.xg = 36'(rnd_trig(70'(m1_reg.p_cdx) + 70'(m1_reg.p_sdy)));
        m2_next.yg = 36'(rnd_trig(70'(m1_reg.p_cdy) - 70'(m1_reg.p_sdx)));
        m2_next.py = m1_reg.ortho ? '0 : (m1_reg.left ? h : -h);
        m2_next.xz = 1'b0;
        m2_next.yz = 1'b0;
        m2_next.sz = 1'b0;
    end

    // M3: numerator base and degenerate flags
    back_t              m3_next, m3_reg;
    logic signed [36:0] t_reg;

    always_comb
    begin
        m3_next    = m2_reg;
        m3_next.xz = (m2_reg.xg == '0);
        m3_next.yz = (m2_reg.yg == '0);
        m3_next.sz = m2_reg.dz || (m2_reg.ds == '0);
    end

    // M4: numerator
    back_t              m4_reg;
    logic signed [68:0] num_reg;

    // D0: magnitudes with rounding bias
    back_t        d0_b_reg;
    logic [68:0]  nsum_reg;
    logic [28:0]  ad_reg;
    logic         neg_reg;
    logic [68:0]  an;
    logic [31:0]  ads;

    always_comb
    begin
        an  = num_reg[68] ? 69'(-num_reg) : 69'(num_reg);
        ads = m4_reg.ds[31] ? 32'(-m4_reg.ds) : 32'(m4_reg.ds);
    end

    // divider: one quotient bit a stage
    div_t        dinit;
    div_t        dv_reg [QUOT_BITS];
    logic [32:0] hi;

    always_comb
    begin
        hi        = nsum_reg[68:QUOT_BITS];
        dinit.b   = d0_b_reg;
        dinit.neg = neg_reg;
        dinit.ovf = (hi >= {4'b0, ad_reg});
        dinit.rem = dinit.ovf ? '0 : hi[29:0];
        dinit.ad  = ad_reg;
        dinit.lo  = nsum_reg[QUOT_BITS-1:0];
        dinit.q   = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_reg[0] <= div_step(dinit);
            for (int k = 1; k < QUOT_BITS; k++)
                dv_reg[k] <= div_step(dv_reg[k-1]);
        end
    end

    // F1: clamp and sign the quotient
    div_t               dq;
    back_t              f1_b_reg;
    logic signed [35:0] qs_reg;
    logic [34:0]        qmag;
    assign dq   = dv_reg[QUOT_BITS-1];
    assign qmag = (dq.ovf || (dq.q > 36'(IX_LIMIT))) ? IX_LIMIT : dq.q[34:0];

    // F2: intersection
    logic signed [36:0] ixs;
    logic signed [35:0] ix_next, ix_reg;
    logic signed [34:0] iy_reg;
    logic signed [31:0] f2_rx_reg, f2_ry_reg, f2_pc_reg, f2_ps_reg;
    logic               ok_next, ok_reg;

    always_comb
    begin
        ixs = 37'(f1_b_reg.xg) + 37'(qs_reg);
        if (ixs > $signed({2'b00, IX_LIMIT}))
            ix_next = $signed({1'b0, IX_LIMIT});
        else if (ixs < -$signed({2'b00, IX_LIMIT}))
            ix_next = -$signed({1'b0, IX_LIMIT});
        else
            ix_next = ixs[35:0];
        if (f1_b_reg.xz)
            ix_next = '0;
        ok_next = !f1_b_reg.yz && (f1_b_reg.xz || !f1_b_reg.sz);
    end

    // F3: rotate back
    logic signed [67:0] f3_a_reg, f3_b_reg, f3_c_reg, f3_e_reg;
    logic signed [31:0] f3_rx_reg, f3_ry_reg;
    logic               f3_ok_reg;

    // F4: world position
    guess_t res_next, res_reg;
    always_comb
    begin
        res_next.guess_valid = f3_ok_reg;
        res_next.guess_x = sat32(43'(f3_rx_reg)
                                 + 43'(rnd_trig(70'(f3_a_reg) - 70'(f3_b_reg))));
        res_next.guess_y = sat32(43'(f3_ry_reg)
                                 + 43'(rnd_trig(70'(f3_c_reg) + 70'(f3_e_reg))));
        if (!f3_ok_reg)
        begin
            res_next.guess_x = '0;
            res_next.guess_y = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_reg   <= m1_next;
            m2_reg   <= m2_next;
            m3_reg   <= m3_next;
            t_reg    <= 37'(m2_reg.py) - 37'(m2_reg.yg);
            m4_reg   <= m3_reg;
            num_reg  <= t_reg * m3_reg.dc;
            d0_b_reg <= m4_reg;
            nsum_reg <= an + 69'(ads[28:1]);
            ad_reg   <= ads[28:0];
            neg_reg  <= num_reg[68] ^ m4_reg.ds[31];
            f1_b_reg <= dq.b;
            qs_reg   <= dq.neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
            ix_reg    <= ix_next;
            iy_reg    <= f1_b_reg.py;
            ok_reg    <= ok_next;
            f2_rx_reg <= f1_b_reg.rx;
            f2_ry_reg <= f1_b_reg.ry;
            f2_pc_reg <= f1_b_reg.pc;
            f2_ps_reg <= f1_b_reg.ps;
            f3_a_reg  <= f2_pc_reg * ix_reg;
            f3_b_reg  <= 68'(f2_ps_reg * iy_reg);
            f3_c_reg  <= f2_ps_reg * ix_reg;
            f3_e_reg  <= 68'(f2_pc_reg * iy_reg);
            f3_rx_reg <= f2_rx_reg;
            f3_ry_reg <= f2_ry_reg;
            f3_ok_reg <= ok_reg;
            res_reg   <= res_next;
        end
    end

    // valid bits: A, CORDIC line, M1..M4, D0, divider, F1..F3, output
    localparam int NV = CORDIC_LAT + QUOT_BITS + 10;
    logic [NV-1:0] v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[NV-2:0], pose_valid};
    end

    assign va_reg    = v_reg[0];
    assign cdv_reg   = v_reg[CORDIC_LAT:1];
    assign res_valid = v_reg[NV-1];
    assign res       = res_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.guess_valid |-> res.guess_x == '0 && res.guess_y == '0)
        else $error("invalid guess with nonzero position");

    assert property (@(posedge clk) disable iff (!rst_n)
        pose_valid && !pose_stall |=> va_reg)
        else $error("accepted item lost at entry");

    assert property (@(posedge clk) disable iff (!rst_n)
        cdv_reg[CORDIC_LAT-1] && en |=> v_reg[CORDIC_LAT+1])
        else $error("item dropped after trig stage");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(v_reg))
        else $error("pipeline moved under stall");

endmodule

`default_nettype wire

// File: sv/tcig_cordic.sv
// ----------------------------------------------------------------------------
// tcig_cordic
// Pipelined rotation CORDIC, one step per stage, Q28 cosine and sine out.
// ----------------------------------------------------------------------------
`default_nettype none

module tcig_cordic (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic [31:0]        ang,
    output logic signed [31:0]      cos_q,
    output logic signed [31:0]      sin_q
);
    import tcig_pkg::*;

    logic signed [33:0] x_reg [CORDIC_STEPS+1];
    logic signed [33:0] y_reg [CORDIC_STEPS+1];
    logic signed [31:0] z_reg [CORDIC_STEPS+1];
    logic [1:0]         quad_reg [CORDIC_STEPS+1];
    logic signed [31:0] cos_reg;
    logic signed [31:0] sin_reg;
    logic signed [34:0] c_next;
    logic signed [34:0] s_next;

    always_comb
    begin
        x_reg[0]    = CORDIC_GAIN;
        y_reg[0]    = '0;
        z_reg[0]    = {2'b00, ang[29:0]};
        quad_reg[0] = ang[31:30];
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        logic signed [33:0] sx;
        logic signed [33:0] sy;
        assign sx = y_reg[i] >>> i;
        assign sy = x_reg[i] >>> i;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quad_reg[i+1] <= quad_reg[i];
                if (!z_reg[i][31])
                begin
                    x_reg[i+1] <= x_reg[i] - sx;
                    y_reg[i+1] <= y_reg[i] + sy;
                    z_reg[i+1] <= z_reg[i] - $signed(ATAN_TURNS[i]);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + sx;
                    y_reg[i+1] <= y_reg[i] - sy;
                    z_reg[i+1] <= z_reg[i] + $signed(ATAN_TURNS[i]);
                end
            end
        end
    end

    always_comb
    begin
        unique case (quad_reg[CORDIC_STEPS])
            2'd0:
            begin
                c_next = 35'(x_reg[CORDIC_STEPS]);
                s_next = 35'(y_reg[CORDIC_STEPS]);
            end
            2'd1:
            begin
                c_next = -35'(y_reg[CORDIC_STEPS]);
                s_next = 35'(x_reg[CORDIC_STEPS]);
            end
            2'd2:
            begin
                c_next = -35'(x_reg[CORDIC_STEPS]);
                s_next = -35'(y_reg[CORDIC_STEPS]);
            end
            default:
            begin
                c_next = 35'(y_reg[CORDIC_STEPS]);
                s_next = -35'(x_reg[CORDIC_STEPS]);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= 32'((c_next + 35'sd2) >>> 2);
            sin_reg <= 32'((s_next + 35'sd2) >>> 2);
        end
    end

    assign cos_q = cos_reg;
    assign sin_q = sin_reg;

endmodule

`default_nettype wire
